[rtl/mlh_pkg.sv]
// ----------------------------------------------------------------------------
// mlh_pkg
// Types and constants shared by the multilinear hash block: stream packing,
// key entry layout, pipeline control and message byte masking.
// ----------------------------------------------------------------------------
package mlh_pkg;

    localparam int LANES     = 4;
    localparam int LANE_W    = 64;
    localparam int HALF_W    = 32;
    localparam int MSG_W     = 32;
    localparam int COUNT_W   = 10;
    localparam int KIDX_W    = 10;
    localparam int NB_W      = 3;

    localparam logic [NB_W-1:0] MSG_BYTES = 3'd4;

    // stream widths (payload rounded up to whole bytes)
    localparam int S_TDATA_W = 336;
    localparam int M_TDATA_W = 272;

    // input word layout
    localparam int S_KIDX_LO    = 0;
    localparam int S_HIGH_LO    = 10;
    localparam int S_LOW_LO     = 266;
    localparam int S_RESTART    = 298;
    localparam int S_MSG_LO     = 299;
    localparam int S_NB_LO      = 331;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_HASH = 1'b1
    } mode_t;

    typedef logic [LANES-1:0][LANE_W-1:0] lane_vec_t;

    typedef struct packed {
        logic [HALF_W-1:0] low;
        lane_vec_t         high;
    } key_entry_t;

    localparam int KEY_ENTRY_W = $bits(key_entry_t);

    typedef struct packed {
        logic load_prod;
        logic load_term;
    } mix_ctl_t;

    function automatic logic [MSG_W-1:0] msg_byte_mask(input logic [NB_W-1:0] nb);
        logic [MSG_W-1:0] m;
        case (nb)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            3'd4:    m = 32'hFFFF_FFFF;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

[rtl/mlh_ram.sv]
// ----------------------------------------------------------------------------
// mlh_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module mlh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mlh_mix.sv]
// ----------------------------------------------------------------------------
// mlh_mix
// Two-stage mixing datapath: nine 32x32 products registered, then the four
// 64-bit lane terms (high word times message plus upper half of the
// neighboring 32-bit key part times message) registered.
// ----------------------------------------------------------------------------
module mlh_mix
    import mlh_pkg::*;
(
    input  logic             aclk,
    input  mix_ctl_t         ctl,
    input  key_entry_t       key,
    input  logic [MSG_W-1:0] msg,
    output lane_vec_t        term
);

    lane_vec_t         prod_lo_next, prod_hi_next;
    lane_vec_t         prod_lo_reg, prod_hi_reg;
    logic [LANE_W-1:0] prod_side_next, prod_side_reg;
    lane_vec_t         term_next, term_reg;
    logic [LANES-1:0][HALF_W-1:0] side_up;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            prod_lo_next[i] = {32'b0, key.high[i][HALF_W-1:0]} * {32'b0, msg};
            prod_hi_next[i] = {32'b0, key.high[i][LANE_W-1:HALF_W]} * {32'b0, msg};
        end
        prod_side_next = {32'b0, key.low} * {32'b0, msg};
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_prod) begin
            prod_lo_reg   <= prod_lo_next;
            prod_hi_reg   <= prod_hi_next;
            prod_side_reg <= prod_side_next;
        end
    end

    // lane 0 pairs with the low key word, lane i with the top half of lane i-1
    always_comb begin
        side_up[0] = prod_side_reg[LANE_W-1:HALF_W];
        for (int i = 1; i < LANES; i++) begin
            side_up[i] = prod_hi_reg[i-1][LANE_W-1:HALF_W];
        end
        for (int i = 0; i < LANES; i++) begin
            term_next[i] = prod_lo_reg[i]
                         + {prod_hi_reg[i][HALF_W-1:0], 32'b0}
                         + {32'b0, side_up[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_term) begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

[rtl/multilinear_hash_256.sv]
// ----------------------------------------------------------------------------
// multilinear_hash_256
// Multilinear universal hash with a 256-bit accumulator in four 64-bit lanes
// and a key memory of KEY_DEPTH entries.
// ----------------------------------------------------------------------------
// The block takes one word per clock, load or hash, while its input is not
// stalled. A hash word is registered in turn at the key memory read, the
// 32x32 products, the lane sums and the accumulator XOR into the output
// register, which holds the result. Loads write the key memory at
// once and give no result. Only the word position counter and the
// accumulator carry from one word to the next, so a stalled output only
// stops input once the four pipeline slots are full. The high words of key
// entry 0 are mirrored in registers so a restart needs no second memory read.
// ----------------------------------------------------------------------------
module multilinear_hash_256
    import mlh_pkg::*;
#(
    parameter int KEY_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // key_index, key_high_a, key_high_b, key_high_c, key_high_d, key_low_word,
    // restart, msg_word, valid_bytes
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // mode
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // hash_a, hash_b, hash_c, hash_d, word_count, overflow
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(KEY_DEPTH);

    // input unpacking
    mode_t             in_mode;
    logic [KIDX_W-1:0] in_kidx;
    lane_vec_t         in_high;
    logic [HALF_W-1:0] in_low;
    logic              in_restart;
    logic [MSG_W-1:0]  in_msg;
    logic [NB_W-1:0]   in_nb;

    assign in_mode    = mode_t'(s_axis_tuser);
    assign in_kidx    = s_axis_tdata[S_KIDX_LO +: KIDX_W];
    assign in_high    = s_axis_tdata[S_HIGH_LO +: LANES*LANE_W];
    assign in_low     = s_axis_tdata[S_LOW_LO +: HALF_W];
    assign in_restart = s_axis_tdata[S_RESTART];
    assign in_msg     = s_axis_tdata[S_MSG_LO +: MSG_W];
    assign in_nb      = s_axis_tdata[S_NB_LO +: NB_W];

    // handshake and pipeline control
    logic in_acc, hash_acc, load_acc;
    logic en2, en3, out_load;
    logic v1_reg, v2_reg, v3_reg, out_v_reg;
    logic v1_next, v2_next, v3_next, out_v_next;

    assign out_load      = v3_reg && (!out_v_reg || m_axis_tready);
    assign en3           = v2_reg && (!v3_reg || out_load);
    assign en2           = v1_reg && (!v2_reg || en3);
    assign s_axis_tready = !v1_reg || en2;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign hash_acc      = in_acc && (in_mode == MODE_HASH);
    assign load_acc      = in_acc && (in_mode == MODE_LOAD);

    always_comb begin
        v1_next    = hash_acc ? 1'b1 : (en2 ? 1'b0 : v1_reg);
        v2_next    = en2 ? 1'b1 : (en3 ? 1'b0 : v2_reg);
        v3_next    = en3 ? 1'b1 : (out_load ? 1'b0 : v3_reg);
        out_v_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_v_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            v3_reg    <= v3_next;
            out_v_reg <= out_v_next;
        end
    end

    // key loads
    logic [31:0]   kidx_ext;
    logic          kidx_ok;
    logic [AW-1:0] waddr;
    logic          key_we;
    key_entry_t    wentry;
    lane_vec_t     seed_reg;

    assign kidx_ext = {22'b0, in_kidx};
    assign kidx_ok  = kidx_ext < 32'(KEY_DEPTH);
    assign waddr    = kidx_ext[AW-1:0];
    assign key_we   = load_acc && kidx_ok;
    assign wentry   = '{low: in_low, high: in_high};

    // mirror of entry 0 high words for restart seeding
    always_ff @(posedge aclk) begin
        if (key_we && (in_kidx == '0)) begin
            seed_reg <= in_high;
        end
    end

    // word position and read address
    logic [AW-1:0]   pos_reg, pos_next, pos_eff;
    logic [AW:0]     k_wide;
    logic            k_ok;
    logic [NB_W-1:0] nb;
    logic            absorb, ovf;

    always_comb begin
        pos_eff  = in_restart ? '0 : pos_reg;
        nb       = (in_nb > MSG_BYTES) ? MSG_BYTES : in_nb;
        k_wide   = {1'b0, pos_eff} + (AW+1)'(1);
        k_ok     = k_wide < (AW+1)'(KEY_DEPTH);
        absorb   = (nb != '0) && k_ok;
        ovf      = (nb != '0) && !k_ok;
        pos_next = absorb ? k_wide[AW-1:0] : pos_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (hash_acc) begin
            pos_reg <= pos_next;
        end
    end

    key_entry_t rentry;

    mlh_ram #(
        .WIDTH(KEY_ENTRY_W),
        .DEPTH(KEY_DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (waddr),
        .wdata (wentry),
        .re    (hash_acc),
        .raddr (k_wide[AW-1:0]),
        .rdata (rentry)
    );

    // side information traveling with each hash word
    logic [MSG_W-1:0] msg1_reg;
    logic             restart1_reg, restart2_reg, restart3_reg;
    logic             absorb1_reg, absorb2_reg, absorb3_reg;
    logic             ovf1_reg, ovf2_reg, ovf3_reg;
    logic [AW-1:0]    pos1_reg, pos2_reg, pos3_reg;
    lane_vec_t        seed1_reg, seed2_reg, seed3_reg;

    always_ff @(posedge aclk) begin
        if (hash_acc) begin
            msg1_reg     <= in_msg & msg_byte_mask(nb);
            restart1_reg <= in_restart;
            absorb1_reg  <= absorb;
            ovf1_reg     <= ovf;
            pos1_reg     <= pos_next;
            seed1_reg    <= seed_reg;
        end
        if (en2) begin
            restart2_reg <= restart1_reg;
            absorb2_reg  <= absorb1_reg;
            ovf2_reg     <= ovf1_reg;
            pos2_reg     <= pos1_reg;
            seed2_reg    <= seed1_reg;
        end
        if (en3) begin
            restart3_reg <= restart2_reg;
            absorb3_reg  <= absorb2_reg;
            ovf3_reg     <= ovf2_reg;
            pos3_reg     <= pos2_reg;
            seed3_reg    <= seed2_reg;
        end
    end

    mix_ctl_t  mix_ctl;
    lane_vec_t term;

    assign mix_ctl = '{load_prod: en2, load_term: en3};

    mlh_mix u_mix (
        .aclk (aclk),
        .ctl  (mix_ctl),
        .key  (rentry),
        .msg  (msg1_reg),
        .term (term)
    );

    // accumulator doubles as the output hash register
    lane_vec_t          acc_reg, acc_next, acc_base;
    logic [31:0]        pos3_ext;
    logic [COUNT_W-1:0] cnt_out_reg;
    logic               ovf_out_reg;

    always_comb begin
        acc_base = restart3_reg ? seed3_reg : acc_reg;
        acc_next = absorb3_reg ? (acc_base ^ term) : acc_base;
        pos3_ext = 32'(pos3_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (out_load) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            cnt_out_reg <= pos3_ext[COUNT_W-1:0];
            ovf_out_reg <= ovf3_reg;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {5'b0, ovf_out_reg, cnt_out_reg, acc_reg};

    // a refused word is only possible at the last key position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && ovf3_reg) |-> (pos3_reg == AW'(KEY_DEPTH - 1)))
        else $error("overflow flagged below the last key position");

    // a word is never both absorbed and refused
    assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> !(absorb1_reg && ovf1_reg))
        else $error("word marked absorbed and refused");

    // position stays inside the key memory
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= AW'(KEY_DEPTH - 1))
        else $error("word position past key memory");

    // input stalls only when the first stage is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> v1_reg)
        else $error("input stalled with empty pipeline");

    // accumulator moves only when a result enters the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_load |=> $stable(acc_reg))
        else $error("accumulator changed without a result");

endmodule

[sim/tb_multilinear_hash_256.sv]
// ----------------------------------------------------------------------------
// tb_multilinear_hash_256
// Self-checking bench for the 256-bit multilinear hash. A short table of
// key loads and hash words walks the corner cases, then random hash
// sessions run with random idling on both streams. A last short session
// restarts and hashes one word of every byte count.
// Digest words are checked against a local model of the accumulator, or against the table where a row gives one.
// ----------------------------------------------------------------------------
module tb_multilinear_hash_256;
    import mlh_pkg::*;

    localparam int KEY_DEPTH      = 1024;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int RANDOM_WORDS   = 520;

    localparam logic [LANE_W-1:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [MSG_W-1:0]  ONES32 = 32'hFFFF_FFFF;

    typedef struct packed {
        mode_t                       mode;
        logic [KIDX_W-1:0]           kidx;
        logic [LANES-1:0][LANE_W-1:0] high;
        logic [HALF_W-1:0]           low;
        logic                        restart;
        logic [MSG_W-1:0]            msg;
        logic [NB_W-1:0]             nb;
    } hash_word_t;

    typedef struct packed {
        logic [LANES-1:0][LANE_W-1:0] lanes;
        logic [COUNT_W-1:0]           count;
        logic                         ovf;
    } hash_res_t;

    typedef struct packed {
        hash_word_t w;
        logic       typed;
        hash_res_t  res;
    } dir_row_t;

    localparam hash_res_t NO_RES = '0;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    multilinear_hash_256 #(
        .KEY_DEPTH (KEY_DEPTH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // model state
    logic [LANES-1:0][LANE_W-1:0] key_high [KEY_DEPTH];
    logic [HALF_W-1:0]            key_low  [KEY_DEPTH];
    bit                           key_loaded [KEY_DEPTH];
    logic [LANES-1:0][LANE_W-1:0] lane_acc = '0;
    int                           word_pos = 0;

    hash_res_t pending_digests [$];

    int n_errors   = 0;
    int n_results  = 0;
    int n_loads    = 0;
    int n_hashes   = 0;
    int n_partial  = 0;
    int n_empty    = 0;
    int n_restarts = 0;
    int n_refused  = 0;
    int send_quiet = 0;

    // key 0 all ones, key 1 all ones, key 2 zero, then single-bit and
    // striped patterns; hash rows cover every byte count from 0 to 7
    localparam int N_DIRECTED = 23;
    dir_row_t directed_rows [N_DIRECTED] = '{
        // empty word straight after reset: lanes still zero
        '{'{MODE_HASH, 10'h3FF, '0, 32'h0, 1'b0, ONES32, 3'd0}, 1'b1, '{'0, 10'd0, 1'b0}},
        '{'{MODE_LOAD, 10'd0, {4{ONES64}}, ONES32, 1'b0, 32'h0, 3'd0}, 1'b0, NO_RES},
        '{'{MODE_LOAD, 10'd1, {4{ONES64}}, ONES32, 1'b0, 32'h0, 3'd0}, 1'b0, NO_RES},
        // full word at position 0 without a restart: no seeding
        '{'{MODE_HASH, 10'd0, '0, 32'h0, 1'b0, ONES32, 3'd4}, 1'b0, NO_RES},
        '{'{MODE_LOAD, 10'd2, '0, 32'h0, 1'b0, 32'h0, 3'd0}, 1'b0, NO_RES},
        '{'{MODE_LOAD, 10'd3, {64'h8000_0000_0000_0001, 64'h0123_4567_89AB_CDEF,
            64'hFEDC_BA98_7654_3210, 64'h8000_0000_0000_0000},
            32'h8000_0000, 1'b0, 32'h0, 3'd0}, 1'b0, NO_RES},
        '{'{MODE_LOAD, 10'h3FF, {64'hCAFE_F00D_1234_5678, 64'h0BAD_C0DE_9ABC_DEF0,
            64'h1357_9BDF_2468_ACE0, 64'hFEED_FACE_0000_FFFF},
            32'hDEAD_BEEF, 1'b1, ONES32, 3'd7}, 1'b0, NO_RES},
        // restart with an empty word: lanes seeded from key 0
        '{'{MODE_HASH, 10'd0, '0, 32'h0, 1'b1, 32'h1234_5678, 3'd0}, 1'b1,
            '{{4{ONES64}}, 10'd0, 1'b0}},
        '{'{MODE_HASH, 10'd0, '0, 32'h0, 1'b1, ONES32, 3'd4}, 1'b0, NO_RES},
        '{'{MODE_HASH, 10'd0, '0, 32'h0, 1'b0, ONES32, 3'd7}, 1'b0, NO_RES},
        '{'{MODE_HASH, 10'd0, '0, 32'h0, 1'b0, 32'h8765_4321, 3'd1}, 1'b0, NO_RES},
        '{'{MODE_LOAD, 10'd4, {64'h1111_1111_1111_1111, 64'h2222_2222_2222_2222,
            64'h3333_3333_3333_3333, 64'h4444_4444_4444_4444},
            32'h5555_5555, 1'b0, 32'h0, 3'd0}, 1'b0, NO_RES},
        '{'{MODE_LOAD, 10'd5, {4{64'hAAAA_AAAA_AAAA_AAAA}}, 32'hAAAA_AAAA,
            1'b0, 32'h0, 3'd0}, 1'b0, NO_RES},
        '{'{MODE_LOAD, 10'd6, {4{64'h5555_5555_5555_5555}}, 32'h5555_5555,
            1'b0, 32'h0, 3'd0}, 1'b0, NO_RES},
        '{'{MODE_HASH, 10'd0, '0, 32'h0, 1'b0, 32'hA5A5_5A5A, 3'd2}, 1'b0, NO_RES},
        '{'{MODE_HASH, 10'd0, '0, 32'h0, 1'b0, 32'h0, 3'd0}, 1'b0, NO_RES},
        '{'{MODE_HASH, 10'd0, '0, 32'h0, 1'b0, ONES32, 3'd3}, 1'b0, NO_RES},
        '{'{MODE_HASH, 10'd0, '0, 32'h0, 1'b0, 32'h0, 3'd4}, 1'b0, NO_RES},
        '{'{MODE_LOAD, 10'd7, {64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
            64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF},
            32'h0000_0001, 1'b0, 32'h0, 3'd0}, 1'b0, NO_RES},
        '{'{MODE_HASH, 10'd0, '0, 32'h0, 1'b0, 32'hC3C3_3C3C, 3'd5}, 1'b0, NO_RES},
        '{'{MODE_LOAD, 10'd8, {64'h7FFF_FFFF_FFFF_FFFF, 64'h1,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h1},
            32'h7FFF_FFFF, 1'b0, 32'h0, 3'd0}, 1'b0, NO_RES},
        '{'{MODE_HASH, 10'd0, '0, 32'h0, 1'b0, 32'h0000_0001, 3'd6}, 1'b0, NO_RES},
        '{'{MODE_HASH, 10'd0, '0, 32'h0, 1'b1, 32'h0, 3'd0}, 1'b1,
            '{{4{ONES64}}, 10'd0, 1'b0}}
    };

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(8 * TIMEOUT_CYCLES);
        $display("Verification failed");
        $finish;
    end

    function automatic logic [LANE_W-1:0] lane_term(input logic [LANE_W-1:0] high,
                                                     input logic [HALF_W-1:0] side,
                                                     input logic [MSG_W-1:0]  m);
        logic [LANE_W-1:0] side_prod;
        side_prod = {32'h0, side} * {32'h0, m};
        return high * {32'h0, m} + (side_prod >> 32);
    endfunction

    // updates the key store and accumulator; a hash word yields one digest
    task automatic absorb_word(input hash_word_t w, output bit emits, output hash_res_t r);
        logic [NB_W-1:0]  nb;
        logic [MSG_W-1:0] m;
        bit               ovf;
        int               k;
        int               i;
        emits = 1'b0;
        r     = '0;
        ovf   = 1'b0;
        if (w.mode == MODE_LOAD) begin
            if (w.kidx < KEY_DEPTH) begin
                key_high[w.kidx]   = w.high;
                key_low[w.kidx]    = w.low;
                key_loaded[w.kidx] = 1'b1;
            end
            n_loads++;
            return;
        end
        n_hashes++;
        if (w.restart) begin
            word_pos = 0;
            lane_acc = key_high[0];
            n_restarts++;
        end
        nb = (w.nb > MSG_BYTES) ? MSG_BYTES : w.nb;
        if (nb == 0) begin
            n_empty++;
        end else begin
            k = word_pos + 1;
            if (k >= KEY_DEPTH) begin
                ovf = 1'b1;
                n_refused++;
            end else begin
                if (nb < MSG_BYTES) n_partial++;
                m = (nb == MSG_BYTES) ? w.msg : w.msg & ((32'd1 << (8 * nb)) - 32'd1);
                lane_acc[0] ^= lane_term(key_high[k][0], key_low[k], m);
                for (i = 1; i < LANES; i++)
                    lane_acc[i] ^= lane_term(key_high[k][i], key_high[k][i-1][63:32], m);
                word_pos = k;
            end
        end
        r.lanes = lane_acc;
        r.count = word_pos[COUNT_W-1:0];
        r.ovf   = ovf;
        emits   = 1'b1;
    endtask

    function automatic int pick_gap();
        int r;
        if (send_quiet > 0) begin
            send_quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            send_quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic issue_word(input hash_word_t w, input bit typed, input hash_res_t typed_res);
        int        gap;
        bit        emits;
        hash_res_t r;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.mode;
        s_axis_tdata  <= S_TDATA_W'({w.nb, w.msg, w.restart, w.low, w.high, w.kidx});
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        absorb_word(w, emits, r);
        if (emits) pending_digests.push_back(typed ? typed_res : r);
    endtask

    function automatic logic [LANE_W-1:0] rand_key_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return ONES64;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [MSG_W-1:0] rand_word32();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return ONES32;
        return $urandom;
    endfunction

    function automatic logic [NB_W-1:0] rand_nb();
        if ($urandom_range(0, 99) < 70) return MSG_BYTES;
        return NB_W'($urandom_range(0, 7));
    endfunction

    function automatic hash_word_t make_load(input logic [KIDX_W-1:0] idx);
        hash_word_t w;
        int         i;
        w.mode = MODE_LOAD;
        w.kidx = idx;
        for (i = 0; i < LANES; i++) w.high[i] = rand_key_word();
        w.low     = rand_word32();
        // fields a load ignores carry noise
        w.restart = 1'($urandom_range(0, 1));
        w.msg     = $urandom;
        w.nb      = NB_W'($urandom_range(0, 7));
        return w;
    endfunction

    function automatic hash_word_t make_hash(input bit rs, input logic [NB_W-1:0] nb,
                                             input logic [MSG_W-1:0] msg);
        hash_word_t w;
        int         i;
        w.mode = MODE_HASH;
        w.kidx = KIDX_W'($urandom);
        for (i = 0; i < LANES; i++) w.high[i] = {$urandom, $urandom};
        w.low     = $urandom;
        w.restart = rs;
        w.msg     = msg;
        w.nb      = nb;
        return w;
    endfunction

    // a hash word may only touch key entries that hold a value
    task automatic feed_hash(input hash_word_t w);
        int p;
        p = w.restart ? 0 : word_pos;
        if (w.nb != 0 && p + 1 < KEY_DEPTH && !key_loaded[p + 1])
            issue_word(make_load(KIDX_W'(p + 1)), 1'b0, NO_RES);
        issue_word(w, 1'b0, NO_RES);
    endtask

    always @(posedge aclk) begin : check_digests
        hash_res_t got;
        hash_res_t want;
        string     lane_name [LANES];
        int        i;
        lane_name = '{"hash_a", "hash_b", "hash_c", "hash_d"};
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.lanes = m_axis_tdata[LANES*LANE_W-1:0];
            got.count = m_axis_tdata[LANES*LANE_W +: COUNT_W];
            got.ovf   = m_axis_tdata[LANES*LANE_W + COUNT_W];
            n_results++;
            if (pending_digests.size() == 0) begin
                $error("digest word with no hash word pending");
                n_errors++;
            end else begin
                want = pending_digests.pop_front();
                for (i = 0; i < LANES; i++) begin
                    if (got.lanes[i] !== want.lanes[i]) begin
                        $error("%s mismatch: expected %h, got %h",
                               lane_name[i], want.lanes[i], got.lanes[i]);
                        n_errors++;
                    end
                end
                if (got.count !== want.count) begin
                    $error("word_count mismatch: expected %0d, got %0d",
                           want.count, got.count);
                    n_errors++;
                end
                if (got.ovf !== want.ovf) begin
                    $error("overflow mismatch: expected %b, got %b", want.ovf, got.ovf);
                    n_errors++;
                end
            end
        end
    end

    // output side: random stalls, quiet stretches, and one long hold-off
    initial begin
        int  hold;
        int  quiet;
        int  r;
        bit  squeezed;
        hold     = 0;
        quiet    = 0;
        squeezed = 1'b0;
        forever begin
            @(negedge aclk);
            if (!squeezed && n_results >= 40) begin
                squeezed = 1'b1;
                hold     = 300;
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else if (quiet > 0) begin
                m_axis_tready <= 1'b1;
                quiet--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) quiet = $urandom_range(20, 80);
                if (r < 65) begin
                    m_axis_tready <= 1'b1;
                end else if (r < 95) begin
                    m_axis_tready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end else begin
                    m_axis_tready <= 1'b0;
                    hold = $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin
        int i;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++)
            issue_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].res);

        // random sessions: mostly hash words, loads mixed in as noise
        for (i = 0; i < RANDOM_WORDS; i++) begin
            if ($urandom_range(0, 99) < 20)
                issue_word(make_load($urandom_range(0, 1) ? KIDX_W'($urandom_range(0, 40))
                                                          : KIDX_W'($urandom)),
                           1'b0, NO_RES);
            else
                feed_hash(make_hash($urandom_range(0, 11) == 0, rand_nb(), rand_word32()));
        end

        // restart, then one word of every byte count
        feed_hash(make_hash(1'b1, MSG_BYTES, rand_word32()));
        for (i = 0; i < 8; i++)
            feed_hash(make_hash(1'b0, NB_W'(i), rand_word32()));
        feed_hash(make_hash(1'b1, MSG_BYTES, rand_word32()));

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_digests.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("run: %0d key loads, %0d hash words, %0d digests checked",
                 n_loads, n_hashes, n_results);
        $display("run: %0d partial, %0d empty, %0d restarts, %0d refused at key end",
                 n_partial, n_empty, n_restarts, n_refused);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
